### rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants of the radix string converter.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int BASE_W = 6;   // width of a radix register
    localparam int CHAR_W = 8;   // width of an ASCII code
    localparam int CNT_W  = 6;   // digit count, holds 0..32
    localparam int IDX_W  = 5;   // digit buffer address

    localparam logic [CNT_W-1:0]  MAX_DIGITS = 6'd32;

    localparam logic [CHAR_W-1:0] CHAR_ALPHA_MIN = 8'd65;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_OFS = 8'd55;  // 'A' - 10
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_OFS = 8'd48;  // '0'
    localparam logic [BASE_W-1:0] DIGIT_DEC_LIM  = 6'd10;  // first letter digit

    localparam logic [BASE_W-1:0] SRC_BASE_RST = 6'd10;
    localparam logic [BASE_W-1:0] DST_BASE_RST = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MIN     = 6'd2;

    // configuration register indexes
    localparam logic CFG_SRC_BASE = 1'b0;
    localparam logic CFG_DST_BASE = 1'b1;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_READ,
        BK_LOAD
    } t_back_state;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] digit_count;
    } t_back_stat;

endpackage

### rtl/rsc_ifs.sv
// ----------------------------------------------------------------------------
// rsc_ifs
// Valid/ready channels of the radix string converter.
// ----------------------------------------------------------------------------
interface rsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, in_char, in_last, input ready);
    modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface rsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       out_last;

    modport source (output valid, out_char, out_last, input ready);
    modport sink   (input valid, out_char, out_last, output ready);
endinterface

interface rsc_val_if #(
    parameter int WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] value;

    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);
endinterface

### rtl/rsc_front.sv
// ----------------------------------------------------------------------------
// rsc_front
// Maps each character to a digit and folds it into the accumulator;
// the finished value of a string is pushed to the queue.
// ----------------------------------------------------------------------------
module rsc_front #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rsc_pkg::BASE_W-1:0] i_src_base,
    rsc_in_if.sink                     i_in,
    rsc_val_if.source                  o_val
);
    import rsc_pkg::*;

    logic [ACC_WIDTH-1:0] r_acc;
    logic [ACC_WIDTH-1:0] n_acc;
    logic [ACC_WIDTH-1:0] w_digit;
    logic [ACC_WIDTH-1:0] w_prod;
    logic                 w_take;

    always_comb begin
        // codes below '0' wrap around the accumulator width
        if (i_in.in_char >= CHAR_ALPHA_MIN) begin
            w_digit = ACC_WIDTH'(i_in.in_char) - ACC_WIDTH'(CHAR_ALPHA_OFS);
        end else begin
            w_digit = ACC_WIDTH'(i_in.in_char) - ACC_WIDTH'(CHAR_DIGIT_OFS);
        end
        w_prod = r_acc * ACC_WIDTH'(i_src_base);
        n_acc  = w_prod + w_digit;
    end

    assign i_in.ready  = o_val.ready;
    assign w_take      = i_in.valid && i_in.ready;
    assign o_val.valid = i_in.valid && i_in.in_last;
    assign o_val.value = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_take) begin
            r_acc <= i_in.in_last ? '0 : n_acc;
        end
    end

endmodule

### rtl/rsc_fifo.sv
// ----------------------------------------------------------------------------
// rsc_fifo
// Two-entry queue of accumulated values between front and back.
// ----------------------------------------------------------------------------
module rsc_fifo #(
    parameter int WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsc_val_if.sink   i_push,
    rsc_val_if.source o_pop
);
    import rsc_pkg::*;

    logic [WIDTH-1:0] r_data [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             w_push;
    logic             w_pop;

    assign i_push.ready = (r_count != 2'd2);
    assign o_pop.valid  = (r_count != 2'd0);
    assign o_pop.value  = r_data[r_rptr];
    assign w_push       = i_push.valid && i_push.ready;
    assign w_pop        = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wptr] <= i_push.value;
        end
    end

endmodule

### rtl/rsc_back.sv
// ----------------------------------------------------------------------------
// rsc_back
// Splits a value into digits of the destination base with a bit-serial
// divider, buffers them, and plays them out most significant first.
// ----------------------------------------------------------------------------
module rsc_back #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rsc_pkg::BASE_W-1:0] i_dst_base,
    rsc_val_if.sink                    i_val,
    rsc_out_if.source                  o_out,
    output rsc_pkg::t_back_stat        o_stat
);
    import rsc_pkg::*;

    localparam int BIT_W = $clog2(ACC_WIDTH);

    t_back_state          r_state, n_state;
    logic [ACC_WIDTH-1:0] r_quot, n_quot;
    logic [BASE_W-1:0]    r_rem, n_rem;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic [BASE_W-1:0]    r_base, n_base;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    logic [BASE_W-1:0]    r_rd_data;
    logic                 r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]    r_out_char, n_out_char;
    logic                 r_out_last, n_out_last;

    logic [BASE_W-1:0]    r_mem [1 << IDX_W];

    logic [BASE_W:0]      w_trial;
    logic                 w_ge;
    logic [BASE_W-1:0]    w_rem_step;
    logic [ACC_WIDTH-1:0] w_quot_step;
    logic [CNT_W-1:0]     w_cnt_inc;
    logic [CHAR_W-1:0]    w_dig_char;
    logic                 w_we;
    logic                 w_re;

    // one restoring step: remainder stays below the base, fits BASE_W bits
    always_comb begin
        w_trial     = {r_rem, r_quot[ACC_WIDTH-1]};
        w_ge        = (w_trial >= {1'b0, r_base});
        w_rem_step  = w_ge ? BASE_W'(w_trial - {1'b0, r_base}) : w_trial[BASE_W-1:0];
        w_quot_step = {r_quot[ACC_WIDTH-2:0], w_ge};
        w_cnt_inc   = r_cnt + CNT_W'(1);
        if (r_rd_data >= DIGIT_DEC_LIM) begin
            w_dig_char = CHAR_W'(r_rd_data) + CHAR_ALPHA_OFS;
        end else begin
            w_dig_char = CHAR_W'(r_rd_data) + CHAR_DIGIT_OFS;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        w_we        = 1'b0;
        w_re        = 1'b0;
        i_val.ready = (r_state == BK_IDLE);

        case (r_state)
            BK_IDLE: begin
                if (i_val.valid) begin
                    n_quot  = i_val.value;
                    n_rem   = '0;
                    n_bit   = BIT_W'(ACC_WIDTH - 1);
                    n_cnt   = '0;
                    n_base  = (i_dst_base < BASE_MIN) ? BASE_MIN : i_dst_base;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                n_quot = w_quot_step;
                n_rem  = w_rem_step;
                n_bit  = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    // digit done: store it, then divide the quotient again
                    w_we  = 1'b1;
                    n_cnt = w_cnt_inc;
                    n_rem = '0;
                    n_bit = BIT_W'(ACC_WIDTH - 1);
                    if (w_quot_step == '0 || w_cnt_inc >= MAX_DIGITS) begin
                        n_rd_idx = r_cnt[IDX_W-1:0];
                        n_state  = BK_READ;
                    end
                end
            end
            BK_READ: begin
                w_re    = 1'b1;
                n_state = BK_LOAD;
            end
            BK_LOAD: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_char  = w_dig_char;
                    n_out_last  = (r_rd_idx == '0);
                    if (r_rd_idx == '0) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx - IDX_W'(1);
                        n_state  = BK_READ;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot     <= n_quot;
        r_rem      <= n_rem;
        r_bit      <= n_bit;
        r_base     <= n_base;
        r_rd_idx   <= n_rd_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_cnt[IDX_W-1:0]] <= w_rem_step;
        end
        if (w_re) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.out_last = r_out_last;

    assign o_stat.busy        = (r_state != BK_IDLE) || r_out_valid;
    assign o_stat.digit_count = r_cnt;

endmodule

### rtl/radix_string_converter.sv
// ----------------------------------------------------------------------------
// radix_string_converter
// Converts an ASCII digit string from one radix to another.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one character per item, most significant first; in_last
//   closes a string. o_out returns the converted digits as ASCII, most
//   significant first, out_last on the final one. A zero value gives "0".
//   Radixes must be written through i_cfg_we/i_cfg_idx/i_cfg_data while
//   idle, unenforced by the block; index 0 is the source radix, index 1 the destination radix.
// Timing:
//   A character that is not last is taken every cycle while the queue is
//   not full. The last one hands the value to a two-entry queue; the
//   converter behind it finds each output digit with a serial divider, one
//   quotient bit per cycle, stores it in a buffer, and then reads the
//   buffer back through its read and load states. The front keeps
//   accumulating the next string meanwhile; it stalls only when the queue
//   is full.
// Reset and stall:
//   Reset clears the accumulator, the queue and the output register and
//   sets the radixes to 10 and 2. A stalled o_out holds its digit and
//   pauses the readout, and with it the back end; the front runs on until
//   the queue is full.
// ----------------------------------------------------------------------------
module radix_string_converter #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [rsc_pkg::BASE_W-1:0] i_cfg_data,
    rsc_in_if.sink                     i_in,
    rsc_out_if.source                  o_out
);
    import rsc_pkg::*;

    logic [BASE_W-1:0] r_src_base;
    logic [BASE_W-1:0] r_dst_base;
    t_back_stat        w_stat;

    rsc_val_if #(.WIDTH(ACC_WIDTH)) w_push ();
    rsc_val_if #(.WIDTH(ACC_WIDTH)) w_pop ();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_base <= SRC_BASE_RST;
            r_dst_base <= DST_BASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC_BASE: r_src_base <= i_cfg_data;
                CFG_DST_BASE: r_dst_base <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rsc_front #(.ACC_WIDTH(ACC_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_src_base (r_src_base),
        .i_in       (i_in),
        .o_val      (w_push)
    );

    rsc_fifo #(.WIDTH(ACC_WIDTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_pop   (w_pop)
    );

    rsc_back #(.ACC_WIDTH(ACC_WIDTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dst_base (r_dst_base),
        .i_val      (w_pop),
        .o_out      (o_out),
        .o_stat     (w_stat)
    );

`ifndef SYNTH
    a_digit_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.digit_count <= MAX_DIGITS)
        else $error("digit count above buffer depth");

    a_out_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> w_stat.busy)
        else $error("output valid while back end idle");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");
`endif

endmodule
